// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands used by the edge stream top module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is asserted
`define RSED_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion, also checked during reset
`define RSED_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/rsed_pkg.sv =====
// ----------------------------------------------------------------------------
// rsed_pkg
// Types, constants and the luma function of the RGB Sobel edge stream.
// ----------------------------------------------------------------------------
package rsed_pkg;

  localparam int unsigned PixW         = 8;
  localparam int unsigned SideW        = 3;
  localparam int unsigned LineWidthW   = 11;
  localparam int unsigned FrameHeightW = 13;
  localparam int unsigned RowW         = 12;
  localparam int unsigned CfgIdxW      = 1;
  localparam int unsigned CfgDataW     = 13;
  localparam int unsigned WinN         = 9;
  localparam int unsigned GradW        = 10;
  localparam int unsigned MagW         = 11;

  localparam int unsigned DefaultMaxLineWidth = 1024;

  localparam logic [LineWidthW-1:0]   LineWidthRst   = LineWidthW'(640);
  localparam logic [FrameHeightW-1:0] FrameHeightRst = FrameHeightW'(480);
  localparam logic [FrameHeightW-1:0] RowLimit       = FrameHeightW'(4096);

  localparam logic [15:0] LumaKr    = 16'd77;
  localparam logic [15:0] LumaKg    = 16'd150;
  localparam logic [15:0] LumaKb    = 16'd29;
  localparam logic [15:0] LumaRound = 16'd128;

  localparam logic [MagW-1:0] MagSat = MagW'(255);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LINE_WIDTH   = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [PixW-1:0]  red;
    logic [PixW-1:0]  green;
    logic [PixW-1:0]  blue;
    logic [SideW-1:0] byte_keep;
    logic [SideW-1:0] byte_strobe;
    logic             stream_id;
    logic             stream_dest;
  } in_word_t;

  typedef struct packed {
    logic [PixW-1:0]  edge_value;
    logic             frame_start;
    logic             line_end;
    logic [SideW-1:0] keep_out;
    logic [SideW-1:0] strobe_out;
    logic             id_out;
    logic             dest_out;
  } out_word_t;

  typedef struct packed {
    logic rd;
    logic wr;
  } lb_ctrl_t;

  function automatic logic [PixW-1:0] luma_of(
    input logic [PixW-1:0] r,
    input logic [PixW-1:0] g,
    input logic [PixW-1:0] b
  );
    logic [15:0] acc;
    acc = LumaKr * 16'(r) + LumaKg * 16'(g) + LumaKb * 16'(b) + LumaRound;
    return acc[15:8];
  endfunction

endpackage

// ===== src/rsed_stream_if.sv =====
// ----------------------------------------------------------------------------
// rsed_stream_if
// Valid/ready stream channel carrying one word of a given payload type.
// ----------------------------------------------------------------------------
interface rsed_stream_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/rgb_sobel_edge_stream_top.sv =====
// ----------------------------------------------------------------------------
// rgb_sobel_edge_stream_top
// RGB pixel stream to 3x3 Sobel L1 edge magnitude stream.
// ----------------------------------------------------------------------------
// Usage:
//   pix_s takes one RGB pixel word per handshake in raster order; edge_m
//   returns one edge word per pixel, in order. The edge value is the
//   saturated |Gx|+|Gy| of the 3x3 luma window ending at the pixel, zero on
//   the frame border and where fewer than two rows or columns precede it.
//   Configure line width and frame height through cfg_we_i/cfg_idx_i/
//   cfg_data_i only while the stream is idle.
//   A word accepted on pix_s is registered in the window stage and then in
//   the output register, from which edge_m offers it.
//   Throughput: one word per cycle while edge_m is ready; the two line stores
//   are read once on acceptance, written once when the window stage advances.
//   Reset clears both counters, the window and the pipeline valid flags;
//   the registers return to 640 x 480. Line store contents are not cleared,
//   so no start-up sweep is needed.
//   When edge_m stalls, the output register and one staged word hold, and
//   pix_s stays ready until both are full.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rgb_sobel_edge_stream_top #(
  parameter int unsigned MAX_LINE_WIDTH = rsed_pkg::DefaultMaxLineWidth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rsed_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rsed_pkg::CfgDataW-1:0] cfg_data_i,
  rsed_stream_if.sink                   pix_s,
  rsed_stream_if.source                 edge_m
);
  import rsed_pkg::*;

  localparam int unsigned XW = (MAX_LINE_WIDTH > 1) ? $clog2(MAX_LINE_WIDTH) : 1;
  localparam int unsigned CW = (XW + 1 > LineWidthW) ? XW + 1 : LineWidthW;

  logic [LineWidthW-1:0]   line_width_q;
  logic [FrameHeightW-1:0] frame_height_q;
  logic [XW-1:0]           x_q;
  logic [RowW-1:0]         y_q;

  logic [CW-1:0]           lw_ext, w_lim;
  logic [FrameHeightW-1:0] h_lim;
  logic                    last_col, last_row, border, accept, s1_adv;

  logic                    s1_valid_q;
  logic [PixW-1:0]         s1_luma_q;
  logic [XW-1:0]           s1_col_q;
  logic                    s1_clr_q, s1_en_q, s1_fs_q, s1_le_q;
  logic [SideW-1:0]        s1_keep_q, s1_strobe_q;
  logic                    s1_id_q, s1_dest_q;

  logic                    out_valid_q;
  out_word_t               out_q;

  lb_ctrl_t                lb_ctrl;
  logic [PixW-1:0]         top1, top2, mag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q   <= LineWidthRst;
      frame_height_q <= FrameHeightRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_LINE_WIDTH:   line_width_q   <= cfg_data_i[LineWidthW-1:0];
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i[FrameHeightW-1:0];
      endcase
    end
  end

  always_comb begin
    lw_ext   = CW'(line_width_q);
    w_lim    = (lw_ext == '0) ? CW'(1) :
               (lw_ext > CW'(MAX_LINE_WIDTH)) ? CW'(MAX_LINE_WIDTH) : lw_ext;
    h_lim    = (frame_height_q == '0) ? FrameHeightW'(1) :
               (frame_height_q > RowLimit) ? RowLimit : frame_height_q;
    last_col = CW'(x_q) >= (w_lim - CW'(1));
    last_row = FrameHeightW'(y_q) >= (h_lim - FrameHeightW'(1));
    border   = (x_q == '0) || (y_q == '0) || last_col || last_row;
  end

  assign s1_adv      = s1_valid_q && (!out_valid_q || edge_m.ready);
  assign pix_s.ready = !s1_valid_q || s1_adv;
  assign accept      = pix_s.valid && pix_s.ready;

  // advance column and row position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0;
      y_q <= '0;
    end else if (accept) begin
      if (last_col) begin
        x_q <= '0;
        y_q <= last_row ? '0 : y_q + RowW'(1);
      end else begin
        x_q <= x_q + XW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (pix_s.ready) begin
      s1_valid_q <= pix_s.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_luma_q   <= luma_of(pix_s.data.red, pix_s.data.green, pix_s.data.blue);
      s1_col_q    <= x_q;
      s1_clr_q    <= (x_q == '0);
      s1_en_q     <= (x_q >= XW'(2)) && (y_q >= RowW'(2)) && !border;
      s1_fs_q     <= (x_q == '0) && (y_q == '0);
      s1_le_q     <= last_col;
      s1_keep_q   <= pix_s.data.byte_keep;
      s1_strobe_q <= pix_s.data.byte_strobe;
      s1_id_q     <= pix_s.data.stream_id;
      s1_dest_q   <= pix_s.data.stream_dest;
    end
  end

  assign lb_ctrl.rd = accept;
  assign lb_ctrl.wr = s1_adv;

  rsed_line_buf #(
    .DEPTH (MAX_LINE_WIDTH),
    .AW    (XW)
  ) u_line_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (lb_ctrl),
    .rd_addr_i (x_q),
    .wr_addr_i (s1_col_q),
    .wr_luma_i (s1_luma_q),
    .top1_o    (top1),
    .top2_o    (top2)
  );

  rsed_sobel u_sobel (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (s1_adv),
    .clr_i  (s1_clr_q),
    .top2_i (top2),
    .top1_i (top1),
    .luma_i (s1_luma_q),
    .mag_o  (mag)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (edge_m.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q.edge_value  <= s1_en_q ? mag : '0;
      out_q.frame_start <= s1_fs_q;
      out_q.line_end    <= s1_le_q;
      out_q.keep_out    <= s1_keep_q;
      out_q.strobe_out  <= s1_strobe_q;
      out_q.id_out      <= s1_id_q;
      out_q.dest_out    <= s1_dest_q;
    end
  end

  assign edge_m.valid = out_valid_q;
  assign edge_m.data  = out_q;

  `RSED_ASSERT(a_stall_only_full, clk_i, rst_ni, !pix_s.ready |-> (s1_valid_q && out_valid_q), "input stalled with a free stage")
  `RSED_ASSERT(a_border_zero, clk_i, rst_ni, out_valid_q && (out_q.frame_start || out_q.line_end) |-> (out_q.edge_value == '0), "nonzero edge on frame border")
  `RSED_ASSERT(a_frame_wrap, clk_i, rst_ni, accept && last_col && last_row |=> (x_q == '0) && (y_q == '0), "position did not wrap at frame end")
  `RSED_ASSERT(a_col_step, clk_i, rst_ni, accept && !last_col |=> (x_q == $past(x_q) + XW'(1)) && $stable(y_q), "column did not step by one")

endmodule

// ===== src/rsed_line_buf.sv =====
// ----------------------------------------------------------------------------
// rsed_line_buf
// Two luma line stores with registered read and write-to-read bypass.
// ----------------------------------------------------------------------------
module rsed_line_buf #(
  parameter int unsigned DEPTH = rsed_pkg::DefaultMaxLineWidth,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  rsed_pkg::lb_ctrl_t        ctrl_i,
  input  logic [AW-1:0]             rd_addr_i,
  input  logic [AW-1:0]             wr_addr_i,
  input  logic [rsed_pkg::PixW-1:0] wr_luma_i,
  output logic [rsed_pkg::PixW-1:0] top1_o,
  output logic [rsed_pkg::PixW-1:0] top2_o
);
  import rsed_pkg::*;

  logic [PixW-1:0] line1_mem [DEPTH];
  logic [PixW-1:0] line2_mem [DEPTH];
  logic [PixW-1:0] rd1_q, rd2_q;
  logic [PixW-1:0] byp1_q, byp2_q;
  logic            byp_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr) begin
      line1_mem[wr_addr_i] <= wr_luma_i;
      line2_mem[wr_addr_i] <= top1_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd) begin
      rd1_q  <= line1_mem[rd_addr_i];
      rd2_q  <= line2_mem[rd_addr_i];
      byp1_q <= wr_luma_i;
      byp2_q <= top1_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else if (ctrl_i.rd) begin
      byp_q <= ctrl_i.wr && (rd_addr_i == wr_addr_i);
    end
  end

  assign top1_o = byp_q ? byp1_q : rd1_q;
  assign top2_o = byp_q ? byp2_q : rd2_q;

endmodule

// ===== src/rsed_sobel.sv =====
// ----------------------------------------------------------------------------
// rsed_sobel
// 3x3 luma window and saturated L1 Sobel gradient magnitude.
// ----------------------------------------------------------------------------
module rsed_sobel (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  logic                      clr_i,
  input  logic [rsed_pkg::PixW-1:0] top2_i,
  input  logic [rsed_pkg::PixW-1:0] top1_i,
  input  logic [rsed_pkg::PixW-1:0] luma_i,
  output logic [rsed_pkg::PixW-1:0] mag_o
);
  import rsed_pkg::*;

  logic [PixW-1:0]  win_q [WinN];
  logic [PixW-1:0]  win_d [WinN];
  logic [GradW-1:0] gx_pos, gx_neg, gy_pos, gy_neg;
  logic [GradW-1:0] gx_abs, gy_abs;
  logic [MagW-1:0]  mag;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_d[r*3]     = clr_i ? '0 : win_q[r*3 + 1];
      win_d[r*3 + 1] = clr_i ? '0 : win_q[r*3 + 2];
    end
    win_d[2] = top2_i;
    win_d[5] = top1_i;
    win_d[8] = luma_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WinN; i++) win_q[i] <= '0;
    end else if (adv_i) begin
      win_q <= win_d;
    end
  end

  always_comb begin
    gx_pos = GradW'(win_d[2]) + GradW'({win_d[5], 1'b0}) + GradW'(win_d[8]);
    gx_neg = GradW'(win_d[0]) + GradW'({win_d[3], 1'b0}) + GradW'(win_d[6]);
    gy_pos = GradW'(win_d[6]) + GradW'({win_d[7], 1'b0}) + GradW'(win_d[8]);
    gy_neg = GradW'(win_d[0]) + GradW'({win_d[1], 1'b0}) + GradW'(win_d[2]);
    gx_abs = (gx_pos >= gx_neg) ? gx_pos - gx_neg : gx_neg - gx_pos;
    gy_abs = (gy_pos >= gy_neg) ? gy_pos - gy_neg : gy_neg - gy_pos;
    mag    = MagW'(gx_abs) + MagW'(gy_abs);
    mag_o  = (mag > MagSat) ? PixW'(MagSat) : mag[PixW-1:0];
  end

endmodule
